FILE: design/sipq_pkg.sv
// Shared types and codes for the switch input port queue.
`default_nettype none
package sipq_pkg;

  localparam logic [1:0] ACT_ARRIVE = 2'd0;
  localparam logic [1:0] ACT_CTRL   = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [1:0] CTRL_GRANT = 2'd1;

  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_REQUEST = 2'd1;
  localparam logic [1:0] SEND_FWD     = 2'd2;
  localparam logic [1:0] SEND_RELEASE = 2'd3;

  typedef enum logic [1:0] {
    K_ARRIVE,
    K_CTRL,
    K_TICK,
    K_NONE
  } sipq_kind_t;

  typedef struct packed {
    sipq_kind_t  kind;
    logic [2:0]  dest;
    logic [7:0]  src;
    logic [15:0] dur;
    logic        nag;
  } sipq_item_t;

  typedef struct packed {
    logic [2:0]  dest;
    logic [7:0]  src;
    logic [15:0] dur;
    logic [31:0] stamp;
  } sipq_entry_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [2:0]  port;
    logic [7:0]  source;
    logic [4:0]  queue_length;
    logic [31:0] queue_wait;
    logic        not_a_grant;
    logic        error_flag;
    logic        last;
  } sipq_result_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EXEC,
    ST_SECOND
  } sipq_state_t;

endpackage
`default_nettype wire

FILE: design/sipq_front.sv
// Front part: accepts input words, classifies them and queues them for the back part.
`default_nettype none
module sipq_front #(
  parameter int NUM_PORTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [2:0]          dest_port,
  input  logic [7:0]          src_id,
  input  logic [15:0]         duration_ticks,
  input  logic [1:0]          ctrl_type,
  output logic                item_valid,
  output sipq_pkg::sipq_item_t item,
  input  logic                item_pop
);
  import sipq_pkg::*;

  localparam int MW = ($clog2(NUM_PORTS + 1) > 3) ? $clog2(NUM_PORTS + 1) : 3;
  localparam logic [MW-1:0] NP = MW'(NUM_PORTS);

  sipq_item_t  fq [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  sipq_item_t  cls;
  logic [MW-1:0] dmod;
  logic        push;

  always_comb begin
    dmod = MW'(dest_port);
    for (int i = 0; i < 4; i++) begin
      if (dmod >= NP) begin
        dmod = dmod - NP;
      end
    end
  end

  always_comb begin
    cls.dest = 3'(dmod);
    cls.src  = src_id;
    cls.dur  = duration_ticks;
    cls.nag  = (ctrl_type != CTRL_GRANT);
    case (action)
      ACT_ARRIVE: cls.kind = K_ARRIVE;
      ACT_CTRL:   cls.kind = K_CTRL;
      ACT_TICK:   cls.kind = K_TICK;
      default:    cls.kind = K_NONE;
    endcase
  end

  assign in_stall   = (fill == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (fill != 2'd0);
  assign item       = fq[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !item_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && item_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq[wr_ptr] <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: design/sipq_back.sv
// Back part: packet memory, request/grant/release state and the output register.
`default_nettype none
module sipq_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  sipq_pkg::sipq_item_t  item,
  output logic                  item_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sipq_pkg::sipq_result_t out_res
);
  import sipq_pkg::*;

  localparam int IW = ($clog2(QUEUE_DEPTH) > 0) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  sipq_entry_t  mem [QUEUE_DEPTH];
  sipq_entry_t  rd_q;
  sipq_entry_t  wr_entry;
  logic         mem_we;

  sipq_state_t  state, state_next;
  sipq_item_t   cur;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic         req_active, req_active_next;
  logic         rel_pending, rel_pending_next;
  logic [2:0]   rel_port, rel_port_next;
  logic [15:0]  rel_cd, rel_cd_next;
  logic [31:0]  tick, tick_next;

  sipq_result_t res1, res2, sec_res;
  logic         two;
  logic         out_free;
  logic         exec_fire;
  logic         second_fire;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (item_valid) state_next = ST_EXEC;
      ST_EXEC:   if (out_free) state_next = two ? ST_SECOND : ST_LOAD;
      ST_SECOND: if (out_free) state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    item_pop    = 1'b0;
    exec_fire   = 1'b0;
    second_fire = 1'b0;
    case (state)
      ST_LOAD:   item_pop = item_valid;
      ST_EXEC:   exec_fire = out_free;
      ST_SECOND: second_fire = out_free;
      default:   item_pop = 1'b0;
    endcase
  end

  always_comb begin
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    req_active_next  = req_active;
    rel_pending_next = rel_pending;
    rel_port_next    = rel_port;
    rel_cd_next      = rel_cd;
    tick_next        = tick;
    mem_we           = 1'b0;
    wr_entry.dest    = cur.dest;
    wr_entry.src     = cur.src;
    wr_entry.dur     = cur.dur;
    wr_entry.stamp   = tick;
    two              = 1'b0;
    res1             = '0;
    res2             = '0;
    res1.last        = 1'b1;
    res2.last        = 1'b1;
    case (cur.kind)
      K_ARRIVE: begin
        if (count == FULL_CNT) begin
          res1.error_flag = 1'b1;
        end else begin
          mem_we     = 1'b1;
          tail_next  = (tail == LAST_IDX) ? '0 : tail + IW'(1);
          count_next = count + CW'(1);
          if (!req_active) begin
            req_active_next = 1'b1;
            res1.send_kind  = SEND_REQUEST;
            res1.port       = cur.dest;
            res1.source     = cur.src;
          end
        end
      end
      K_CTRL: begin
        res1.not_a_grant = cur.nag;
        if (count == '0) begin
          res1.error_flag = 1'b1;
        end else begin
          head_next        = (head == LAST_IDX) ? '0 : head + IW'(1);
          count_next       = count - CW'(1);
          rel_pending_next = 1'b1;
          rel_port_next    = rd_q.dest;
          rel_cd_next      = rd_q.dur;
          res1.send_kind   = SEND_FWD;
          res1.port        = rd_q.dest;
          res1.source      = rd_q.src;
          res1.queue_wait  = tick - rd_q.stamp;
        end
      end
      K_TICK: begin
        tick_next = tick + 32'd1;
        if (rel_pending) begin
          if (rel_cd > 16'd1) begin
            rel_cd_next = rel_cd - 16'd1;
          end else begin
            rel_pending_next = 1'b0;
            rel_cd_next      = '0;
            res1.send_kind   = SEND_RELEASE;
            res1.port        = rel_port;
            if (count == '0) begin
              req_active_next = 1'b0;
            end else begin
              req_active_next = 1'b1;
              two             = 1'b1;
              res1.last       = 1'b0;
              res2.send_kind  = SEND_REQUEST;
              res2.port       = rd_q.dest;
              res2.source     = rd_q.src;
            end
          end
        end
      end
      default: res1.last = 1'b1;
    endcase
    res1.queue_length = 5'(count_next);
    res2.queue_length = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      req_active  <= 1'b0;
      rel_pending <= 1'b0;
      rel_port    <= '0;
      rel_cd      <= '0;
      tick        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_fire) begin
        head        <= head_next;
        tail        <= tail_next;
        count       <= count_next;
        req_active  <= req_active_next;
        rel_pending <= rel_pending_next;
        rel_port    <= rel_port_next;
        rel_cd      <= rel_cd_next;
        tick        <= tick_next;
      end
      if (exec_fire || second_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur <= item;
    end
    if (exec_fire) begin
      out_res <= res1;
      sec_res <= res2;
    end else if (second_fire) begin
      out_res <= sec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && mem_we) begin
      mem[tail] <= wr_entry;
    end
    rd_q <= mem[head];
  end

endmodule
`default_nettype wire

FILE: design/switch_input_port_queue_core.sv
// Top level of the switch input port queue: front classifier and back executor.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid / in_stall   | action, dest_port, src_id, duration_ticks, ctrl_type
//   out     | output    | out_valid / out_stall | send_kind, port, source, queue_length,
//           |           |                       | queue_wait, not_a_grant, error_flag, last
//
// In the back part an item is first taken from the two-entry front queue in the load state,
// while the packet memory reads the head entry, and then executed in the execute state.
// A tick that sends a release and a new request gives its second word from a further state.
// Synchronous reset clears all control state; the packet memory is not cleared.
// An output stall holds execution; the front queue keeps accepting until it is full.
`default_nettype none
module switch_input_port_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_PORTS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [2:0]  dest_port,
  input  logic [7:0]  src_id,
  input  logic [15:0] duration_ticks,
  input  logic [1:0]  ctrl_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  send_kind,
  output logic [2:0]  port,
  output logic [7:0]  source,
  output logic [4:0]  queue_length,
  output logic [31:0] queue_wait,
  output logic        not_a_grant,
  output logic        error_flag,
  output logic        last
);
  import sipq_pkg::*;

  logic         item_valid;
  logic         item_pop;
  sipq_item_t   item;
  sipq_result_t res;

  sipq_front #(
    .NUM_PORTS(NUM_PORTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .dest_port      (dest_port),
    .src_id         (src_id),
    .duration_ticks (duration_ticks),
    .ctrl_type      (ctrl_type),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop)
  );

  sipq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign send_kind    = res.send_kind;
  assign port         = res.port;
  assign source       = res.source;
  assign queue_length = res.queue_length;
  assign queue_wait   = res.queue_wait;
  assign not_a_grant  = res.not_a_grant;
  assign error_flag   = res.error_flag;
  assign last         = res.last;

endmodule
`default_nettype wire

FILE: design/sipq_checker.sv
// Port-level checks for the switch input port queue, bound to the top level.
`default_nettype none
module sipq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  send_kind,
  input logic [2:0]  port,
  input logic [7:0]  source,
  input logic [31:0] queue_wait,
  input logic        error_flag,
  input logic        last
);
  import sipq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(send_kind) && $stable(last))
    else $error("output word changed while stalled");

  a_second_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && last && send_kind == SEND_REQUEST)
    else $error("release not followed by a request word");

  a_first_is_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> send_kind == SEND_RELEASE)
    else $error("non-final word is not a release");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> send_kind == SEND_NONE && port == 3'd0 && source == 8'd0)
    else $error("error word carries a send");

  a_wait_only_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_kind != SEND_FWD |-> queue_wait == 32'd0)
    else $error("queue wait on a word that forwards nothing");

endmodule

bind switch_input_port_queue_core sipq_checker u_sipq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .send_kind  (send_kind),
  .port       (port),
  .source     (source),
  .queue_wait (queue_wait),
  .error_flag (error_flag),
  .last       (last)
);
`default_nettype wire

FILE: tb/tb_switch_input_port_queue_core.sv
// Testbench for the switch input port queue: directed rows, then random words against a port model.
module tb_switch_input_port_queue_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sipq_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [1:0] CTRL_REQUEST = 2'd0;
  localparam logic [1:0] CTRL_RELEASE = 2'd2;
  localparam logic [1:0] CTRL_UNDEF   = 2'd3;
  localparam int DEPTH       = 16;
  localparam int PHASE_WORDS = 456;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic [1:0]   act;
    logic [2:0]   dest;
    logic [7:0]   src;
    logic [15:0]  dur;
    logic [1:0]   ctrl;
    bit           typed;
    sipq_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [2:0]  dest_port;
  logic [7:0]  src_id;
  logic [15:0] duration_ticks;
  logic [1:0]  ctrl_type;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  send_kind;
  logic [2:0]  port;
  logic [7:0]  source;
  logic [4:0]  queue_length;
  logic [31:0] queue_wait;
  logic        not_a_grant;
  logic        error_flag;
  logic        last;

  sipq_entry_t  q_store [DEPTH];
  logic [3:0]   q_head = '0;
  logic [3:0]   q_tail = '0;
  logic [4:0]   q_count = '0;
  logic         req_out = 1'b0;
  logic         rel_armed = 1'b0;
  logic [2:0]   rel_port = '0;
  logic [15:0]  rel_left = '0;
  logic [31:0]  ticks = '0;
  sipq_result_t port_msgs [$];
  dir_row_t     dir_rows [$];
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           fail_count = 0;
  int           stuck = 0;

  switch_input_port_queue_core #(.QUEUE_DEPTH(DEPTH), .NUM_PORTS(8)) u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sipq_result_t port_word(logic [1:0] kind, logic [2:0] prt, logic [7:0] src,
      logic [4:0] qlen, logic [31:0] waited, logic nag, logic err, logic fin);
    return '{kind, prt, src, qlen, waited, nag, err, fin};
  endfunction

  task automatic predict_port(input logic [1:0] act, input logic [2:0] dest,
      input logic [7:0] src, input logic [15:0] dur, input logic [1:0] ctrl);
    sipq_entry_t head;
    logic        nag;
    nag = (ctrl != CTRL_GRANT);
    case (act)
      ACT_ARRIVE: begin
        if (q_count >= DEPTH) begin
          port_msgs.push_back(port_word(SEND_NONE, 0, 0, q_count, 0, 0, 1, 1));
        end else begin
          q_store[q_tail] = '{dest, src, dur, ticks};
          q_tail++;
          q_count++;
          if (!req_out) begin
            req_out = 1'b1;
            port_msgs.push_back(port_word(SEND_REQUEST, dest, src, q_count, 0, 0, 0, 1));
          end else begin
            port_msgs.push_back(port_word(SEND_NONE, 0, 0, q_count, 0, 0, 0, 1));
          end
        end
      end
      ACT_CTRL: begin
        if (q_count == 0) begin
          port_msgs.push_back(port_word(SEND_NONE, 0, 0, q_count, 0, nag, 1, 1));
        end else begin
          head = q_store[q_head];
          q_head++;
          q_count--;
          rel_armed = 1'b1;
          rel_port = head.dest;
          rel_left = head.dur;
          port_msgs.push_back(port_word(SEND_FWD, head.dest, head.src, q_count,
                                        ticks - head.stamp, nag, 0, 1));
        end
      end
      ACT_TICK: begin
        ticks++;
        if (!rel_armed || rel_left > 1) begin
          if (rel_armed) rel_left--;
          port_msgs.push_back(port_word(SEND_NONE, 0, 0, q_count, 0, 0, 0, 1));
        end else begin
          rel_armed = 1'b0;
          rel_left = '0;
          if (q_count == 0) begin
            req_out = 1'b0;
            port_msgs.push_back(port_word(SEND_RELEASE, rel_port, 0, q_count, 0, 0, 0, 1));
          end else begin
            req_out = 1'b1;
            port_msgs.push_back(port_word(SEND_RELEASE, rel_port, 0, q_count, 0, 0, 0, 0));
            port_msgs.push_back(port_word(SEND_REQUEST, q_store[q_head].dest,
                                          q_store[q_head].src, q_count, 0, 0, 0, 1));
          end
        end
      end
      default: begin
        port_msgs.push_back(port_word(SEND_NONE, 0, 0, q_count, 0, 0, 0, 1));
      end
    endcase
  endtask

  task automatic add_row(input logic [1:0] act, input logic [2:0] dest, input logic [7:0] src,
      input logic [15:0] dur, input logic [1:0] ctrl, input bit typed, input sipq_result_t want);
    dir_row_t r;
    r.act = act;
    r.dest = dest;
    r.src = src;
    r.dur = dur;
    r.ctrl = ctrl;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic send_word(input logic [1:0] act, input logic [2:0] dest, input logic [7:0] src,
      input logic [15:0] dur, input logic [1:0] ctrl, input bit typed, input sipq_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    dest_port <= dest;
    src_id <= src;
    duration_ticks <= dur;
    ctrl_type <= ctrl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_port(act, dest, src, dur, ctrl);
    if (typed) port_msgs[port_msgs.size() - 1] = want;
  endtask

  task automatic send_random(input bit fill);
    int          r;
    int          p;
    logic [1:0]  act;
    logic [1:0]  ctrl;
    logic [15:0] dur;
    r = $urandom_range(99);
    if (fill) begin
      act = (r < 65) ? ACT_ARRIVE : (r < 80) ? ACT_CTRL : (r < 97) ? ACT_TICK : ACT_UNUSED;
    end else begin
      act = (r < 20) ? ACT_ARRIVE : (r < 50) ? ACT_CTRL : (r < 97) ? ACT_TICK : ACT_UNUSED;
    end
    p = $urandom_range(99);
    if (p < 45) dur = 16'($urandom_range(1));
    else if (p < 90) dur = 16'($urandom_range(6, 2));
    else if (p < 97) dur = 16'($urandom_range(40, 7));
    else dur = 16'($urandom_range(65535));
    ctrl = ($urandom_range(99) < 80) ? CTRL_GRANT : 2'($urandom_range(3));
    send_word(act, 3'($urandom_range(7)), 8'($urandom_range(255)), dur, ctrl, 1'b0, '0);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (port_msgs.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : out_side
    sipq_result_t want;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (port_msgs.size() == 0) begin
        $error("unexpected word: send_kind %0d port %0d source %0d", send_kind, port, source);
        fail_count++;
      end else begin
        want = port_msgs.pop_front();
        check_field("send_kind", want.send_kind, send_kind);
        check_field("port", want.port, port);
        check_field("source", want.source, source);
        check_field("queue_length", want.queue_length, queue_length);
        check_field("queue_wait", want.queue_wait, queue_wait);
        check_field("not_a_grant", want.not_a_grant, not_a_grant);
        check_field("error_flag", want.error_flag, error_flag);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck == STUCK_LIMIT) begin
      $display("tb_switch_input_port_queue_core failed");
      $finish;
    end
  end

  initial begin : stimulus
    int idle_set [4];
    int stall_set [4];
    bit fill;
    idle_set = '{0, 86, 0, 17};
    stall_set = '{0, 0, 86, 17};
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_TICK;
    dest_port <= '0;
    src_id <= '0;
    duration_ticks <= '0;
    ctrl_type <= CTRL_GRANT;

    add_row(ACT_CTRL, 0, 0, 0, CTRL_GRANT, 1, port_word(SEND_NONE, 0, 0, 0, 0, 0, 1, 1));
    add_row(ACT_CTRL, 0, 0, 0, CTRL_REQUEST, 1, port_word(SEND_NONE, 0, 0, 0, 0, 1, 1, 1));
    add_row(ACT_CTRL, 0, 0, 0, CTRL_RELEASE, 1, port_word(SEND_NONE, 0, 0, 0, 0, 1, 1, 1));
    add_row(ACT_CTRL, 7, 255, 16'hFFFF, CTRL_UNDEF, 1,
            port_word(SEND_NONE, 0, 0, 0, 0, 1, 1, 1));
    add_row(ACT_TICK, 0, 0, 0, CTRL_GRANT, 1, port_word(SEND_NONE, 0, 0, 0, 0, 0, 0, 1));
    add_row(ACT_UNUSED, 7, 255, 16'hFFFF, CTRL_UNDEF, 1,
            port_word(SEND_NONE, 0, 0, 0, 0, 0, 0, 1));
    add_row(ACT_ARRIVE, 7, 255, 0, CTRL_GRANT, 1,
            port_word(SEND_REQUEST, 7, 255, 1, 0, 0, 0, 1));
    for (int i = 1; i < DEPTH; i++) begin
      add_row(ACT_ARRIVE, (i == 1) ? 3'd0 : 3'(i), (i == 1) ? 8'd0 : 8'(i * 17),
              (i == 1) ? 16'd1 : (i == 2) ? 16'hFFFF : 16'(i * 4099), CTRL_GRANT, 1,
              port_word(SEND_NONE, 0, 0, 5'(i + 1), 0, 0, 0, 1));
    end
    add_row(ACT_ARRIVE, 5, 8'hAA, 16'h5555, CTRL_GRANT, 1,
            port_word(SEND_NONE, 0, 0, 16, 0, 0, 1, 1));
    add_row(ACT_CTRL, 0, 0, 0, CTRL_REQUEST, 1, port_word(SEND_FWD, 7, 255, 15, 0, 1, 0, 1));
    add_row(ACT_TICK, 0, 0, 0, CTRL_GRANT, 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].act, dir_rows[i].dest, dir_rows[i].src, dir_rows[i].dur,
                dir_rows[i].ctrl, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_drained();

    fill = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) fill = 1'($urandom_range(1));
        send_random(fill);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_switch_input_port_queue_core passed");
    end else begin
      $display("tb_switch_input_port_queue_core failed");
    end
    $finish;
  end

endmodule
